// ===== hdl/rmdf_pkg.sv =====
// Shared types and constants for the recent MAC address duplicate filter.
`timescale 1ns / 1ps

package rmdf_pkg;

   localparam int DEPTH  = 64;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int MAC_W  = 48;
   localparam int HELD_W = 7;

   localparam logic ACT_CHECK = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESPOND
   } state_type;

   // Search token that ripples down the cell row.
   typedef struct packed {
      logic             active;
      logic             hit;
      logic [MAC_W-1:0] key;
   } token_type;

endpackage

// ===== hdl/recent_mac_dedup_filter_unit.sv =====
// Top level of the recent MAC address duplicate filter: cell row, sequencer, result register.
`timescale 1ns / 1ps
// A check walks a search token down the row of DEPTH cells, one cell per cycle; its
//   hit is then held and loaded into the result register when the output is free.
// A new request is taken only after the previous result is loaded; a clear skips the search.
// Reset (synchronous, active high) empties the store and drops any pending result;
//   stored addresses are not cleared and are never compared until rewritten.

module recent_mac_dedup_filter_unit import rmdf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [MAC_W-1:0]  req_mac_address,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_already_seen,
   output logic [HELD_W-1:0] rsp_entries_held
);

   // Sequencer state and held transaction.
   state_type         state_ff, state_in;
   logic              action_ff, action_in;
   logic [MAC_W-1:0]  key_ff, key_in;
   logic              hit_ff, hit_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              seen_ff, seen_in;
   logic [HELD_W-1:0] held_ff, held_in;

   // Sequencer outputs.
   logic              accept;
   logic              launch;
   logic              load_rsp;
   logic              shift_en;
   logic              out_free;

   // Cell row wiring.
   token_type         tok_launch;
   token_type         cell_tok   [DEPTH];
   logic [MAC_W-1:0]  cell_entry [DEPTH];
   logic [DEPTH-1:0]  cell_live;
   logic              token_done;

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign token_done = cell_tok[DEPTH-1].active;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_action == ACT_CLEAR) ? ST_RESPOND : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (token_done) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      launch    = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
            launch    = req_valid & (req_action == ACT_CHECK);
         end
         ST_SEARCH: begin
         end
         ST_RESPOND: begin
            load_rsp = out_free;
         end
         default: begin
         end
      endcase
   end

   // Insert only on a check that missed; all cells shift one place toward the oldest end.
   assign shift_en = load_rsp & (action_ff == ACT_CHECK) & ~hit_ff;

   // Inject the search token straight from the accepted transaction.
   always_comb begin
      tok_launch.active = launch;
      tok_launch.hit    = 1'b0;
      tok_launch.key    = req_mac_address;
   end

   // Hold the transaction, capture the hit, and update the fill count.
   always_comb begin
      action_in = accept ? req_action      : action_ff;
      key_in    = accept ? req_mac_address : key_ff;
      hit_in    = (state_ff == ST_SEARCH && token_done) ? cell_tok[DEPTH-1].hit : hit_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      held_in   = held_ff;
      if (load_rsp) begin
         if (action_ff == ACT_CLEAR) begin
            count_in = '0;
            seen_in  = 1'b0;
         end else if (hit_ff) begin
            seen_in  = 1'b1;
         end else begin
            // Full store: the oldest entry drops off the end, count stays at DEPTH.
            if (count_ff != CNT_W'(DEPTH)) begin
               count_in = count_ff + CNT_W'(1);
            end
            seen_in = 1'b0;
         end
         held_in = HELD_W'(count_in);
      end
      rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
      key_ff    <= key_in;
      hit_ff    <= hit_in;
      seen_ff   <= seen_in;
      held_ff   <= held_in;
   end

   // Cell row: cell 0 holds the newest entry; cells below the fill count are compared.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_live[i] = (CNT_W'(i) < count_ff);
      if (i == 0) begin : g_head
         rmdf_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .tok_in    (tok_launch),
            .live      (cell_live[i]),
            .shift_en  (shift_en),
            .entry_in  (key_ff),
            .tok_out   (cell_tok[i]),
            .entry_out (cell_entry[i])
         );
      end else begin : g_body
         rmdf_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .tok_in    (cell_tok[i-1]),
            .live      (cell_live[i]),
            .shift_en  (shift_en),
            .entry_in  (cell_entry[i-1]),
            .tok_out   (cell_tok[i]),
            .entry_out (cell_entry[i])
         );
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_already_seen = seen_ff;
   assign rsp_entries_held = held_ff;

endmodule

// ===== hdl/rmdf_cell.sv =====
// One entry cell: holds a stored address, compares the passing token, shifts on insert.
`timescale 1ns / 1ps

module rmdf_cell import rmdf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  token_type        tok_in,
   input  logic             live,
   input  logic             shift_en,
   input  logic [MAC_W-1:0] entry_in,
   output token_type        tok_out,
   output logic [MAC_W-1:0] entry_out
);

   token_type        tok_ff;
   token_type        tok_in_nxt;
   logic [MAC_W-1:0] entry_ff;
   logic [MAC_W-1:0] entry_in_nxt;

   always_comb begin
      tok_in_nxt.active = tok_in.active;
      tok_in_nxt.key    = tok_in.key;
      tok_in_nxt.hit    = tok_in.hit | (tok_in.active & live & (entry_ff == tok_in.key));
      entry_in_nxt      = shift_en ? entry_in : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in_nxt.active;
      end
      tok_ff.hit <= tok_in_nxt.hit;
      tok_ff.key <= tok_in_nxt.key;
      entry_ff   <= entry_in_nxt;
   end

   assign tok_out   = tok_ff;
   assign entry_out = entry_ff;

endmodule

// ===== sim/tb_recent_mac_dedup_filter_unit.sv =====
// Testbench for the recent MAC address duplicate filter: queued stimulus, dedup predictor, checker.
`timescale 1ns / 1ps

module tb_recent_mac_dedup_filter_unit;
   import rmdf_pkg::*;

   localparam int RANDOM_ITEMS   = 1350;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int IDLE_LIMIT     = 4000;
   localparam int DRAIN_CYCLES   = DEPTH + 8;

   typedef struct packed {
      logic             action;
      logic [MAC_W-1:0] mac;
   } mac_request_t;

   typedef struct packed {
      logic              seen;
      logic [HELD_W-1:0] held;
   } dedup_verdict_t;

   logic              clock;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic              req_action       = ACT_CHECK;
   logic [MAC_W-1:0]  req_mac_address  = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic              rsp_already_seen;
   logic [HELD_W-1:0] rsp_entries_held;

   recent_mac_dedup_filter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_mac_address  (req_mac_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_already_seen (rsp_already_seen),
      .rsp_entries_held (rsp_entries_held)
   );

   // Stimulus waiting to be offered, and verdicts waiting for their response.
   mac_request_t   pending_requests[$];
   dedup_verdict_t expected_verdicts[$];

   int total_items    = 0;
   int accepted_items = 0;
   int fail_count     = 0;
   int idle_cycles    = 0;
   int holdoff_left   = 0;
   bit holdoff_done   = 1'b0;

   // Predictor state: the address ring, its head and its fill level.
   logic [MAC_W-1:0] known_macs[DEPTH];
   int               ring_head  = 0;
   int               held_count = 0;

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: search the valid part of the ring; insert at the head on
   // a miss, let the count saturate at DEPTH so the oldest entry is
   // overwritten once the ring is full. A clear drops head and count but
   // leaves the stale words behind, invalid.
   // ------------------------------------------------------------------
   function automatic dedup_verdict_t predict_dedup(mac_request_t item);
      dedup_verdict_t verdict;
      logic           hit;
      hit          = 1'b0;
      verdict.seen = 1'b0;
      if (item.action == ACT_CLEAR) begin
         ring_head  = 0;
         held_count = 0;
      end else begin
         for (int k = 0; k < held_count; k++) begin
            if (known_macs[k] == item.mac) hit = 1'b1;
         end
         if (hit) begin
            verdict.seen = 1'b1;
         end else begin
            known_macs[ring_head] = item.mac;
            ring_head = (ring_head + 1) % DEPTH;
            if (held_count < DEPTH) held_count++;
         end
      end
      verdict.held = HELD_W'(held_count);
      return verdict;
   endfunction

   // ------------------------------------------------------------------
   // Pacing: three phases by progress. Sender idles rarely while the
   // receiver stalls a lot, then swap, then run flat out.
   // ------------------------------------------------------------------
   function automatic int sender_idle_pct();
      if (accepted_items < total_items / 3) return 8;
      if (accepted_items < 2 * total_items / 3) return 79;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (accepted_items < total_items / 3) return 79;
      if (accepted_items < 2 * total_items / 3) return 8;
      return 0;
   endfunction

   function automatic logic [MAC_W-1:0] random_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic queue_request(logic action, logic [MAC_W-1:0] mac);
      mac_request_t item;
      item.action = action;
      item.mac    = mac;
      pending_requests.push_back(item);
   endtask

   // Episodes of checks drawn from a small address pool so that repeats hit.
   // Pools above DEPTH force wraparound and eviction of the oldest entries;
   // single-bit neighbors of pool members catch partial compares.
   task automatic build_random_traffic();
      logic [MAC_W-1:0] pool[$];
      logic [MAC_W-1:0] base;
      int               pool_size;
      int               episode_len;
      int               pick;
      int               produced;
      produced = 0;
      while (produced < RANDOM_ITEMS) begin
         pool.delete();
         if ($urandom_range(3) == 0) pool_size = $urandom_range(DEPTH + 1, DEPTH + 32);
         else pool_size = $urandom_range(4, DEPTH - 4);
         for (int k = 0; k < pool_size; k++) begin
            if (k > 0 && $urandom_range(9) == 0) begin
               base = pool[$urandom_range(k - 1)];
               base[$urandom_range(MAC_W - 1)] ^= 1'b1;
               pool.push_back(base);
            end else begin
               pool.push_back(random_mac());
            end
         end
         episode_len = $urandom_range(30, 160);
         for (int n = 0; n < episode_len && produced < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 2) queue_request(ACT_CLEAR, random_mac());
            else if (pick < 8) queue_request(ACT_CHECK, random_mac());
            else queue_request(ACT_CHECK, pool[$urandom_range(pool_size - 1)]);
            produced++;
         end
         if (produced < RANDOM_ITEMS && $urandom_range(9) < 6) begin
            queue_request(ACT_CLEAR, random_mac());
            produced++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      // Directed: clear on an empty store, field extremes, repeats, clear
      // that must invalidate stale words, clear with a nonzero address.
      queue_request(ACT_CLEAR, '0);
      queue_request(ACT_CHECK, '0);
      queue_request(ACT_CHECK, '1);
      queue_request(ACT_CHECK, '0);
      queue_request(ACT_CHECK, '1);
      queue_request(ACT_CHECK, {24{2'b10}});
      queue_request(ACT_CHECK, {24{2'b01}});
      queue_request(ACT_CHECK, {24{2'b10}});
      queue_request(ACT_CHECK, 48'h0000_0000_0001);
      queue_request(ACT_CHECK, 48'h8000_0000_0000);
      queue_request(ACT_CHECK, 48'h7FFF_FFFF_FFFF);
      queue_request(ACT_CHECK, 48'hFFFF_FFFF_FFFE);
      queue_request(ACT_CHECK, 48'h0000_0000_0001);
      queue_request(ACT_CLEAR, '1);
      queue_request(ACT_CHECK, '1);
      queue_request(ACT_CHECK, '0);
      queue_request(ACT_CHECK, '1);
      queue_request(ACT_CLEAR, {24{2'b01}});
      queue_request(ACT_CHECK, {24{2'b01}});
      queue_request(ACT_CHECK, {24{2'b01}});
      build_random_traffic();
      total_items = pending_requests.size();

      wait (accepted_items == total_items);
      wait (expected_verdicts.size() == 0);
      // Give a late stray response time to show up.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Driver: record the transaction accepted at this edge, then advance
   // to the next pending item or drop valid. Hold the payload while
   // stalled.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      mac_request_t next_item;
      mac_request_t taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken.action = req_action;
            taken.mac    = req_mac_address;
            expected_verdicts.push_back(predict_dedup(taken));
            accepted_items++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
               next_item = pending_requests.pop_front();
               req_valid       <= 1'b1;
               req_action      <= next_item.action;
               req_mac_address <= next_item.mac;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver back-pressure. Once, late in the run, hold off for a long
   // stretch while the sender keeps offering, so the block fills and
   // stalls its input.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!holdoff_done && total_items > 0 && accepted_items >= 5 * total_items / 6) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each accepted response with the oldest verdict.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : response_monitor
      dedup_verdict_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected response: already_seen=%0d entries_held=%0d",
                   rsp_already_seen, rsp_entries_held);
            fail_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_already_seen !== want.seen) begin
               $error("already_seen: expected %0d, actual %0d", want.seen, rsp_already_seen);
               fail_count++;
            end
            if (rsp_entries_held !== want.held) begin
               $error("entries_held: expected %0d, actual %0d", want.held, rsp_entries_held);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run when no transaction moves for too long.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
